[rtl/cgps_pkg.sv]
// ----------------------------------------------------------------------------
// cgps_pkg
// Shared types, constants and helpers for the central force particle step.
// ----------------------------------------------------------------------------
package cgps_pkg;

  localparam int W       = 32;   // data word
  localparam int F       = 20;   // fraction bits
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int REG_W   = 31;
  localparam int QW      = 32;   // root and quotient bits
  localparam int SQ_RW   = 64;   // radicand width
  localparam int DIV_NW  = 64;   // dividend width
  localparam int DIV_DW  = 48;   // divisor width
  localparam int R2Q_W   = SQ_RW - F;
  localparam int UNIT_LAT = QW + 1;

  typedef enum logic [CFG_AW-1:0] {
    REG_MASS,
    REG_TIME_STEP,
    REG_VEL_SCALE,
    REG_SPEED_THR,
    REG_HORIZON,
    REG_SOFTENING
  } reg_idx_e;

  typedef logic signed [W-1:0] word_t;

  typedef struct packed {
    logic             alive;
    logic             dead;
    logic             zden;
    logic             norm;
    word_t            px;
    word_t            py;
    word_t            vx0;
    word_t            vy0;
    word_t            vx1;
    word_t            vy1;
    logic [R2Q_W-1:0] r2q;
  } tag_t;

  localparam logic signed [63:0] WMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;

  function automatic word_t sat_word(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > WMAX) begin
      r = WMAX;
    end else if (v < WMIN) begin
      r = WMIN;
    end else begin
      r = v;
    end
    return r[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag_w(input word_t v);
    logic [W-1:0] u;
    u = v;
    return v[W-1] ? (~u + 1'b1) : u;
  endfunction

  // signed result of magnitude q, clamped to the word range
  function automatic word_t sat_quot(input logic [QW-1:0] q, input logic ovf, input logic neg);
    logic [QW:0] lim;
    logic [QW:0] mq;
    logic [QW:0] r;
    lim = neg ? ((QW+1)'(1) << (W - 1)) : (((QW+1)'(1) << (W - 1)) - (QW+1)'(1));
    mq  = (ovf || ({1'b0, q} > lim)) ? lim : {1'b0, q};
    r   = neg ? (~mq + 1'b1) : mq;
    return r[W-1:0];
  endfunction

endpackage

[rtl/central_gravity_photon_step.sv]
// ----------------------------------------------------------------------------
// central_gravity_photon_step
// One semi-implicit Euler step of a particle pulled toward a central mass.
// ----------------------------------------------------------------------------
// One particle is taken per clock cycle; busy_o stays low. Its result comes
// out on done_o for exactly one cycle. The latency is set by the two square
// root pipelines (radius and speed) and the two divider pipelines
// (acceleration and normalization), 33 stages each, plus 16 stages of
// multiply, add and saturate. cfg_ready_o is always high; the user must
// write registers only while no particle is in flight; it is not enforced.
module central_gravity_photon_step import cgps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  input  word_t             pos_x_i,
  input  word_t             pos_y_i,
  input  word_t             vel_x_i,
  input  word_t             vel_y_i,
  input  logic              is_alive_i,
  output logic              done_o,
  output word_t             new_pos_x_o,
  output word_t             new_pos_y_o,
  output word_t             new_vel_x_o,
  output word_t             new_vel_y_o,
  output logic              still_alive_o,
  output logic              point_valid_o
);

  localparam int LATENCY = 16 + 4 * UNIT_LAT;
  localparam int RH_W    = 2 * REG_W - F;

  logic [REG_W-1:0] mass_q, time_q, vscale_q, thr_q, horizon_q, soft_q;
  logic [2*REG_W-1:0] rh_prod;
  logic [RH_W-1:0]    rh_q;

  logic accept;
  logic p0_v_q, p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, p7_v_q;
  logic p8_v_q, p9_v_q, p10_v_q, p12_v_q, p13_v_q, p14_v_q, p15_v_q, p16_v_q;

  tag_t p0_tag_q, p1_tag_q, p2_tag_q, p3_tag_q, p4_tag_q, p5_tag_q, p6_tag_q;
  tag_t p7_tag_q, p8_tag_q, p9_tag_q, p10_tag_q, p12_tag_q, p13_tag_q, p14_tag_q;
  tag_t p15_tag_q;
  tag_t p0_tag_d, p2_tag_d, p3_tag_d, p5_tag_d, p8_tag_d, p12_tag_d, n_tag_in;

  logic [63:0] p1_sqx_q, p1_sqy_q, p1_sqx_d, p1_sqy_d;
  logic [63:0] p2_r2_q, p2_r2_d;
  logic [63:0] p3_lo_q, p3_lo_d;
  logic [R2Q_W-QW+QW-1:0] p3_hi_q, p3_hi_d;
  logic [62:0] p3_nx_q, p3_ny_q, p3_nx_d, p3_ny_d;
  logic [75:0] p4_p_q, p4_p_d;
  logic [62:0] p4_nx_q, p4_ny_q;
  logic [44:0] p5_d_q, p5_d_d;
  logic [62:0] p5_nx_q, p5_ny_q;
  logic [R2Q_W-1:0] r3;
  word_t p6_ax_q, p6_ay_q, p6_ax_d, p6_ay_d;
  logic signed [63:0] p7_ax_q, p7_ay_q, p7_ax_d, p7_ay_d;
  logic [63:0] p9_sx_q, p9_sy_q, p9_sx_d, p9_sy_d;
  logic [63:0] p10_s2_q, p10_s2_d;
  logic signed [63:0] p13_tx_q, p13_ty_q, p13_tx_d, p13_ty_d;
  word_t p14_tx_q, p14_ty_q, p14_tx_d, p14_ty_d;
  logic signed [63:0] p15_sx_q, p15_sy_q, p15_sx_d, p15_sy_d;
  word_t px_d, py_d, vx_d, vy_d;
  logic  still_d, point_d;
  logic signed [63:0] ext_a, ext_b;

  logic          r_v, a_v, s_v, n_v;
  tag_t          r_tag, a_tag, s_tag, n_tag;
  logic [QW-1:0] r_root, s_root, qa_x, qa_y, qn_x, qn_y;
  logic          ova_x, ova_y, ovn_x, ovn_y;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign rh_prod     = mass_q * horizon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q    <= REG_W'(1048576);
      time_q    <= REG_W'(10486);
      vscale_q  <= REG_W'(1048576);
      thr_q     <= REG_W'(1);
      horizon_q <= REG_W'(2097152);
      soft_q    <= REG_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MASS:      mass_q    <= cfg_data_i[REG_W-1:0];
        REG_TIME_STEP: time_q    <= cfg_data_i[REG_W-1:0];
        REG_VEL_SCALE: vscale_q  <= cfg_data_i[REG_W-1:0];
        REG_SPEED_THR: thr_q     <= cfg_data_i[REG_W-1:0];
        REG_HORIZON:   horizon_q <= cfg_data_i[REG_W-1:0];
        REG_SOFTENING: soft_q    <= cfg_data_i[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q  <= 1'b0; p1_v_q  <= 1'b0; p2_v_q  <= 1'b0; p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0; p5_v_q  <= 1'b0; p6_v_q  <= 1'b0; p7_v_q  <= 1'b0;
      p8_v_q  <= 1'b0; p9_v_q  <= 1'b0; p10_v_q <= 1'b0; p12_v_q <= 1'b0;
      p13_v_q <= 1'b0; p14_v_q <= 1'b0; p15_v_q <= 1'b0; p16_v_q <= 1'b0;
    end else begin
      p0_v_q  <= accept;  p1_v_q  <= p0_v_q;  p2_v_q  <= p1_v_q;  p3_v_q  <= r_v;
      p4_v_q  <= p3_v_q;  p5_v_q  <= p4_v_q;  p6_v_q  <= a_v;     p7_v_q  <= p6_v_q;
      p8_v_q  <= p7_v_q;  p9_v_q  <= p8_v_q;  p10_v_q <= p9_v_q;  p12_v_q <= n_v;
      p13_v_q <= p12_v_q; p14_v_q <= p13_v_q; p15_v_q <= p14_v_q; p16_v_q <= p15_v_q;
    end
  end

  always_comb begin
    p0_tag_d       = '0;
    p0_tag_d.alive = is_alive_i;
    p0_tag_d.px    = pos_x_i;
    p0_tag_d.py    = pos_y_i;
    p0_tag_d.vx0   = vel_x_i;
    p0_tag_d.vy0   = vel_y_i;

    p1_sqx_d = 64'(mag_w(p0_tag_q.px)) * 64'(mag_w(p0_tag_q.px));
    p1_sqy_d = 64'(mag_w(p0_tag_q.py)) * 64'(mag_w(p0_tag_q.py));

    p2_r2_d      = p1_sqx_q + p1_sqy_q;
    p2_tag_d     = p1_tag_q;
    p2_tag_d.r2q = p2_r2_d[SQ_RW-1:F];

    p3_tag_d      = r_tag;
    p3_tag_d.dead = RH_W'(r_root) < rh_q;
    p3_lo_d       = 64'(r_tag.r2q[QW-1:0]) * 64'(r_root);
    p3_hi_d       = R2Q_W'(r_tag.r2q[R2Q_W-1:QW]) * R2Q_W'(r_root);
    p3_nx_d       = 63'(mass_q) * 63'(mag_w(r_tag.px));
    p3_ny_d       = 63'(mass_q) * 63'(mag_w(r_tag.py));

    p4_p_d = {p3_hi_q, 32'b0} + 76'(p3_lo_q);

    r3            = (|p4_p_q[75:64]) ? '1 : p4_p_q[63:F];
    p5_d_d        = 45'(r3) + 45'(soft_q);
    p5_tag_d      = p4_tag_q;
    p5_tag_d.zden = (r3 == '0) && (soft_q == '0);

    p6_ax_d = a_tag.zden ? '0 : sat_quot(qa_x, ova_x, !a_tag.px[W-1]);
    p6_ay_d = a_tag.zden ? '0 : sat_quot(qa_y, ova_y, !a_tag.py[W-1]);

    p7_ax_d = $signed(p6_ax_q) * $signed({1'b0, time_q});
    p7_ay_d = $signed(p6_ay_q) * $signed({1'b0, time_q});

    ext_a        = p7_tag_q.vx0;
    ext_b        = p7_tag_q.vy0;
    p8_tag_d     = p7_tag_q;
    p8_tag_d.vx1 = sat_word(ext_a + (p7_ax_q >>> F));
    p8_tag_d.vy1 = sat_word(ext_b + (p7_ay_q >>> F));

    p9_sx_d = 64'(mag_w(p8_tag_q.vx1)) * 64'(mag_w(p8_tag_q.vx1));
    p9_sy_d = 64'(mag_w(p8_tag_q.vy1)) * 64'(mag_w(p8_tag_q.vy1));

    p10_s2_d = p9_sx_q + p9_sy_q;

    n_tag_in      = s_tag;
    n_tag_in.norm = s_root > {1'b0, thr_q};

    p12_tag_d = n_tag;
    if (n_tag.norm) begin
      p12_tag_d.vx1 = sat_quot(qn_x, ovn_x, n_tag.vx1[W-1]);
      p12_tag_d.vy1 = sat_quot(qn_y, ovn_y, n_tag.vy1[W-1]);
    end

    p13_tx_d = $signed(p12_tag_q.vx1) * $signed({1'b0, time_q});
    p13_ty_d = $signed(p12_tag_q.vy1) * $signed({1'b0, time_q});

    p14_tx_d = sat_word(p13_tx_q >>> F);
    p14_ty_d = sat_word(p13_ty_q >>> F);

    p15_sx_d = $signed(p14_tx_q) * $signed({1'b0, vscale_q});
    p15_sy_d = $signed(p14_ty_q) * $signed({1'b0, vscale_q});

    if (p15_tag_q.alive) begin
      px_d    = sat_word($signed(64'(p15_tag_q.px)) + (p15_sx_q >>> F));
      py_d    = sat_word($signed(64'(p15_tag_q.py)) + (p15_sy_q >>> F));
      vx_d    = p15_tag_q.vx1;
      vy_d    = p15_tag_q.vy1;
      still_d = !p15_tag_q.dead;
      point_d = 1'b1;
    end else begin
      px_d    = p15_tag_q.px;
      py_d    = p15_tag_q.py;
      vx_d    = p15_tag_q.vx0;
      vy_d    = p15_tag_q.vy0;
      still_d = 1'b0;
      point_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rh_q      <= rh_prod[2*REG_W-1:F];
    p0_tag_q  <= p0_tag_d;
    p1_tag_q  <= p0_tag_q;
    p1_sqx_q  <= p1_sqx_d;
    p1_sqy_q  <= p1_sqy_d;
    p2_tag_q  <= p2_tag_d;
    p2_r2_q   <= p2_r2_d;
    p3_tag_q  <= p3_tag_d;
    p3_lo_q   <= p3_lo_d;
    p3_hi_q   <= p3_hi_d;
    p3_nx_q   <= p3_nx_d;
    p3_ny_q   <= p3_ny_d;
    p4_tag_q  <= p3_tag_q;
    p4_p_q    <= p4_p_d;
    p4_nx_q   <= p3_nx_q;
    p4_ny_q   <= p3_ny_q;
    p5_tag_q  <= p5_tag_d;
    p5_d_q    <= p5_d_d;
    p5_nx_q   <= p4_nx_q;
    p5_ny_q   <= p4_ny_q;
    p6_tag_q  <= a_tag;
    p6_ax_q   <= p6_ax_d;
    p6_ay_q   <= p6_ay_d;
    p7_tag_q  <= p6_tag_q;
    p7_ax_q   <= p7_ax_d;
    p7_ay_q   <= p7_ay_d;
    p8_tag_q  <= p8_tag_d;
    p9_tag_q  <= p8_tag_q;
    p9_sx_q   <= p9_sx_d;
    p9_sy_q   <= p9_sy_d;
    p10_tag_q <= p9_tag_q;
    p10_s2_q  <= p10_s2_d;
    p12_tag_q <= p12_tag_d;
    p13_tag_q <= p12_tag_q;
    p13_tx_q  <= p13_tx_d;
    p13_ty_q  <= p13_ty_d;
    p14_tag_q <= p13_tag_q;
    p14_tx_q  <= p14_tx_d;
    p14_ty_q  <= p14_ty_d;
    p15_tag_q <= p14_tag_q;
    p15_sx_q  <= p15_sx_d;
    p15_sy_q  <= p15_sy_d;
    new_pos_x_o   <= px_d;
    new_pos_y_o   <= py_d;
    new_vel_x_o   <= vx_d;
    new_vel_y_o   <= vy_d;
    still_alive_o <= still_d;
    point_valid_o <= point_d;
  end

  assign done_o = p16_v_q;

  cgps_sqrt u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p2_v_q),
    .tag_i   (p2_tag_q),
    .rad_i   (p2_r2_q),
    .valid_o (r_v),
    .tag_o   (r_tag),
    .root_o  (r_root)
  );

  cgps_div u_div_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p5_v_q),
    .tag_i   (p5_tag_q),
    .num_a_i (DIV_NW'(p5_nx_q)),
    .num_b_i (DIV_NW'(p5_ny_q)),
    .den_i   (DIV_DW'(p5_d_q)),
    .valid_o (a_v),
    .tag_o   (a_tag),
    .quo_a_o (qa_x),
    .quo_b_o (qa_y),
    .ovf_a_o (ova_x),
    .ovf_b_o (ova_y)
  );

  cgps_sqrt u_sqrt_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p10_v_q),
    .tag_i   (p10_tag_q),
    .rad_i   (p10_s2_q),
    .valid_o (s_v),
    .tag_o   (s_tag),
    .root_o  (s_root)
  );

  cgps_div u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_v),
    .tag_i   (n_tag_in),
    .num_a_i (DIV_NW'({mag_w(s_tag.vx1), F'(0)})),
    .num_b_i (DIV_NW'({mag_w(s_tag.vy1), F'(0)})),
    .den_i   (DIV_DW'(s_root)),
    .valid_o (n_v),
    .tag_o   (n_tag),
    .quo_a_o (qn_x),
    .quo_b_o (qn_y),
    .ovf_a_o (ovn_x),
    .ovf_b_o (ovn_y)
  );

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("start transfer without result at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without matching start transfer");

  a_dead_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !point_valid_o) |-> !still_alive_o)
    else $error("pass-through particle reported alive");
`endif

endmodule

[rtl/cgps_sqrt.sv]
// ----------------------------------------------------------------------------
// cgps_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module cgps_sqrt import cgps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  tag_t             tag_i,
  input  logic [SQ_RW-1:0] rad_i,
  output logic             valid_o,
  output tag_t             tag_o,
  output logic [QW-1:0]    root_o
);

  logic             v_q    [0:QW];
  tag_t             tag_q  [0:QW];
  logic [QW-1:0]    root_q [0:QW];
  logic [SQ_RW-1:0] rad_q  [0:QW-1];
  logic [QW+1:0]    rem_q  [0:QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0]  <= tag_i;
    rad_q[0]  <= rad_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_st
    logic [QW+3:0] ta;
    logic [QW+1:0] trial;
    logic          take;

    always_comb begin
      ta    = {rem_q[k-1], rad_q[k-1][SQ_RW-1 -: 2]};
      trial = {root_q[k-1], 2'b01};
      take  = ta >= {2'b00, trial};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[k]  <= tag_q[k-1];
      root_q[k] <= {root_q[k-1][QW-2:0], take};
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        rad_q[k] <= {rad_q[k-1][SQ_RW-3:0], 2'b00};
        rem_q[k] <= take ? (QW+2)'(ta - {2'b00, trial}) : (QW+2)'(ta);
      end
    end
  end

  assign valid_o = v_q[QW];
  assign tag_o   = tag_q[QW];
  assign root_o  = root_q[QW];

endmodule

[rtl/cgps_div.sv]
// ----------------------------------------------------------------------------
// cgps_div
// Two pipelined restoring dividers sharing one divisor, one quotient bit
// per stage, with a flag for quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module cgps_div import cgps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tag_t              tag_i,
  input  logic [DIV_NW-1:0] num_a_i,
  input  logic [DIV_NW-1:0] num_b_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic              valid_o,
  output tag_t              tag_o,
  output logic [QW-1:0]     quo_a_o,
  output logic [QW-1:0]     quo_b_o,
  output logic              ovf_a_o,
  output logic              ovf_b_o
);

  localparam int CW = DIV_DW + QW;

  logic              v_q     [0:QW];
  tag_t              tag_q   [0:QW];
  logic              ovf_a_q [0:QW];
  logic              ovf_b_q [0:QW];
  logic [QW-1:0]     q_a_q   [0:QW];
  logic [QW-1:0]     q_b_q   [0:QW];
  logic [DIV_DW-1:0] den_q   [0:QW-1];
  logic [DIV_DW-1:0] rem_a_q [0:QW-1];
  logic [DIV_DW-1:0] rem_b_q [0:QW-1];
  logic [QW-1:0]     lo_a_q  [0:QW-1];
  logic [QW-1:0]     lo_b_q  [0:QW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0]   <= tag_i;
    den_q[0]   <= den_i;
    ovf_a_q[0] <= CW'(num_a_i) >= {den_i, QW'(0)};
    ovf_b_q[0] <= CW'(num_b_i) >= {den_i, QW'(0)};
    rem_a_q[0] <= DIV_DW'(num_a_i[DIV_NW-1:QW]);
    rem_b_q[0] <= DIV_DW'(num_b_i[DIV_NW-1:QW]);
    lo_a_q[0]  <= num_a_i[QW-1:0];
    lo_b_q[0]  <= num_b_i[QW-1:0];
    q_a_q[0]   <= '0;
    q_b_q[0]   <= '0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_st
    logic [DIV_DW:0] ta_a;
    logic [DIV_DW:0] ta_b;
    logic            ge_a;
    logic            ge_b;

    always_comb begin
      ta_a = {rem_a_q[k-1], lo_a_q[k-1][QW-1]};
      ta_b = {rem_b_q[k-1], lo_b_q[k-1][QW-1]};
      ge_a = ta_a >= {1'b0, den_q[k-1]};
      ge_b = ta_b >= {1'b0, den_q[k-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[k]   <= tag_q[k-1];
      ovf_a_q[k] <= ovf_a_q[k-1];
      ovf_b_q[k] <= ovf_b_q[k-1];
      q_a_q[k]   <= {q_a_q[k-1][QW-2:0], ge_a};
      q_b_q[k]   <= {q_b_q[k-1][QW-2:0], ge_b};
    end

    if (k < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        den_q[k]   <= den_q[k-1];
        rem_a_q[k] <= ge_a ? DIV_DW'(ta_a - {1'b0, den_q[k-1]}) : DIV_DW'(ta_a);
        rem_b_q[k] <= ge_b ? DIV_DW'(ta_b - {1'b0, den_q[k-1]}) : DIV_DW'(ta_b);
        lo_a_q[k]  <= {lo_a_q[k-1][QW-2:0], 1'b0};
        lo_b_q[k]  <= {lo_b_q[k-1][QW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = v_q[QW];
  assign tag_o   = tag_q[QW];
  assign quo_a_o = q_a_q[QW];
  assign quo_b_o = q_b_q[QW];
  assign ovf_a_o = ovf_a_q[QW];
  assign ovf_b_o = ovf_b_q[QW];

endmodule
